// ----- sv/mm64_pkg.sv -----
// Shared types and constants for the MurmurHash64A message hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
package mm64_pkg;

  // Mixing constant and shift distance of the hash.
  localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MixShift = 47;

  // Halves of the mixing constant for the 32x32 partial products.
  localparam logic [31:0] MixMulLo = MixMul[31:0];
  localparam logic [31:0] MixMulHi = MixMul[63:32];

  // Source of the multiplicand loaded before a multiplication.
  typedef enum logic [2:0] {
    XSEL_LEN,    // total length, zero-extended
    XSEL_WORD,   // full data word
    XSEL_KMIX,   // product with its shift-xor applied
    XSEL_HK,     // running hash xor mixed word
    XSEL_HMASK,  // running hash xor masked short word
    XSEL_HFIN    // running hash with its shift-xor applied
  } xsel_e;

  // Source of a running hash update.
  typedef enum logic [1:0] {
    HSEL_INIT,   // seed xor product
    HSEL_PROD,   // product
    HSEL_FIN     // product with its shift-xor applied
  } hsel_e;

  // Step of the shared multiplier.
  typedef enum logic [1:0] {
    MP_NONE,     // multiplier idle
    MP_LO,       // low x low, full 64-bit product
    MP_HI_LO,    // high operand half x low constant half, upper word only
    MP_LO_HI     // low operand half x high constant half, upper word only
  } mphase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    item_load;
    logic    x_load;
    xsel_e   xsel;
    mphase_e mul_phase;
    logic    h_load;
    hsel_e   hsel;
    logic    hash_load;
  } dp_cmd_t;

  // Status of the latched item, from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic part;
    logic last;
  } dp_sts_t;

endpackage

// ----- sv/mm64_in_if.sv -----
// Input channel of the hasher: one message word per item.
// Self-contained; carries valid, ready and the item fields.
interface mm64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic [31:0] total_length;
  logic        last;

  modport source (output valid, output data_word, output byte_count,
                  output total_length, output last, input ready);
  modport sink   (input valid, input data_word, input byte_count,
                  input total_length, input last, output ready);
endinterface

// ----- sv/mm64_out_if.sv -----
// Output channel of the hasher: one finished hash per item.
// Self-contained; carries valid, ready and the hash.
interface mm64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink   (input valid, input hash, output ready);
endinterface

// ----- sv/mm64_dp.sv -----
// Datapath of the hasher: item latch, seed, running hash, shared multiplier.
// Depends on mm64_pkg for the command and status types and the constants.
module mm64_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [63:0]      cfg_wdata_i,
  input  logic [63:0]      word_i,
  input  logic [3:0]       count_i,
  input  logic [31:0]      len_i,
  input  logic             last_i,
  input  mm64_pkg::dp_cmd_t cmd_i,
  output mm64_pkg::dp_sts_t sts_o,
  output logic [63:0]      hash_o
);
  import mm64_pkg::*;

  logic [63:0] seed_q;
  logic [63:0] word_q;
  logic [3:0]  count_q;
  logic [31:0] len_q;
  logic        last_q;
  logic [63:0] x_q, x_d;
  logic [63:0] p_q, p_d;
  logic [63:0] h_q, h_d;
  logic [63:0] hash_q;
  logic [63:0] mask;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;

  function automatic logic [63:0] shift_xor(input logic [63:0] v);
    shift_xor = v ^ (v >> MixShift);
  endfunction

  // Status of the latched item.
  assign sts_o.full = count_q[3];
  assign sts_o.part = !count_q[3] && (count_q != 4'd0);
  assign sts_o.last = last_q;

  // Byte mask keeping the valid bytes of a short word.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = (4'(b) < count_q) ? 8'hff : 8'h00;
    end
  end

  // Multiplicand selection.
  always_comb begin
    x_d = x_q;
    case (cmd_i.xsel)
      XSEL_LEN:   x_d = {32'd0, len_q};
      XSEL_WORD:  x_d = word_q;
      XSEL_KMIX:  x_d = shift_xor(p_q);
      XSEL_HK:    x_d = h_q ^ p_q;
      XSEL_HMASK: x_d = h_q ^ (word_q & mask);
      XSEL_HFIN:  x_d = shift_xor(h_q);
      default:    x_d = x_q;
    endcase
  end

  // One 32x32 partial product per cycle; the two cross terms only reach the
  // upper word of the 64-bit product.
  assign mul_a    = (cmd_i.mul_phase == MP_HI_LO) ? x_q[63:32] : x_q[31:0];
  assign mul_b    = (cmd_i.mul_phase == MP_LO_HI) ? MixMulHi : MixMulLo;
  assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    p_d = p_q;
    case (cmd_i.mul_phase)
      MP_LO:              p_d = mul_prod;
      MP_HI_LO, MP_LO_HI: p_d = {p_q[63:32] + mul_prod[31:0], p_q[31:0]};
      default:            p_d = p_q;
    endcase
  end

  // Running hash update.
  always_comb begin
    h_d = h_q;
    case (cmd_i.hsel)
      HSEL_INIT: h_d = seed_q ^ p_q;
      HSEL_PROD: h_d = p_q;
      HSEL_FIN:  h_d = shift_xor(p_q);
      default:   h_d = h_q;
    endcase
  end

  // Seed and running hash are state with a defined reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      h_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.h_load) begin
        h_q <= h_d;
      end
    end
  end

  // Item latch, operand, product and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      word_q  <= word_i;
      count_q <= count_i;
      len_q   <= len_i;
      last_q  <= last_i;
    end
    if (cmd_i.x_load) begin
      x_q <= x_d;
    end
    p_q <= p_d;
    if (cmd_i.hash_load) begin
      hash_q <= h_q;
    end
  end

  assign hash_o = hash_q;

endmodule

// ----- sv/mm64_ctrl.sv -----
// Controller of the hasher: sequences the multiplications of each item.
// Depends on mm64_pkg for the command and status types.
module mm64_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mm64_pkg::dp_sts_t sts_i,
  output mm64_pkg::dp_cmd_t cmd_o
);
  import mm64_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_LOAD, S_MUL0, S_MUL1, S_MUL2, S_WB, S_EMIT
  } state_e;

  // One multiplication by the mixing constant and what it serves.
  typedef enum logic [2:0] {
    OP_INIT, OP_K1, OP_K2, OP_HW, OP_HP, OP_FIN
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d, body_op;
  logic   go, body_go;
  logic   first_q, in_msg_q, out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // First multiplication that the word of the item needs, if any.
  always_comb begin
    if (sts_i.full) begin
      body_op = OP_K1;
    end else if (sts_i.part) begin
      body_op = OP_HP;
    end else begin
      body_op = OP_FIN;
    end
    body_go = sts_i.full || sts_i.part || sts_i.last;
  end

  // Choice of the next multiplication and the next state.
  always_comb begin
    go      = 1'b0;
    op_d    = op_q;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        if (first_q) begin
          go   = 1'b1;
          op_d = OP_INIT;
        end else begin
          go   = body_go;
          op_d = body_op;
        end
        state_d = go ? S_LOAD : S_IDLE;
      end
      S_LOAD: state_d = S_MUL0;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_WB;
      S_WB: begin
        unique case (op_q)
          OP_INIT: begin
            go   = body_go;
            op_d = body_op;
          end
          OP_K1: begin
            go   = 1'b1;
            op_d = OP_K2;
          end
          OP_K2: begin
            go   = 1'b1;
            op_d = OP_HW;
          end
          OP_HW, OP_HP: begin
            go   = sts_i.last;
            op_d = OP_FIN;
          end
          default: go = 1'b0;
        endcase
        if (go) begin
          state_d = S_LOAD;
        end else if (op_q == OP_FIN) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.item_load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.x_load    = (state_q == S_LOAD);
    unique case (op_q)
      OP_INIT: cmd_o.xsel = XSEL_LEN;
      OP_K1:   cmd_o.xsel = XSEL_WORD;
      OP_K2:   cmd_o.xsel = XSEL_KMIX;
      OP_HW:   cmd_o.xsel = XSEL_HK;
      OP_HP:   cmd_o.xsel = XSEL_HMASK;
      default: cmd_o.xsel = XSEL_HFIN;
    endcase
    unique case (state_q)
      S_MUL0:  cmd_o.mul_phase = MP_LO;
      S_MUL1:  cmd_o.mul_phase = MP_HI_LO;
      S_MUL2:  cmd_o.mul_phase = MP_LO_HI;
      default: cmd_o.mul_phase = MP_NONE;
    endcase
    if (state_q == S_WB) begin
      unique case (op_q)
        OP_INIT: begin
          cmd_o.h_load = 1'b1;
          cmd_o.hsel   = HSEL_INIT;
        end
        OP_HW, OP_HP: begin
          cmd_o.h_load = 1'b1;
          cmd_o.hsel   = HSEL_PROD;
        end
        OP_FIN: begin
          cmd_o.h_load = 1'b1;
          cmd_o.hsel   = HSEL_FIN;
        end
        default: cmd_o.h_load = 1'b0;
      endcase
    end
    cmd_o.hash_load = (state_q == S_EMIT) && slot_free;
  end

  // State, message tracking and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_INIT;
      first_q     <= 1'b0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (go) begin
        op_q <= op_d;
      end
      if ((state_q == S_IDLE) && in_valid_i) begin
        first_q  <= !in_msg_q;
        in_msg_q <= 1'b1;
      end
      if ((state_q == S_EMIT) && slot_free) begin
        out_valid_q <= 1'b1;
        in_msg_q    <= 1'b0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/murmur2_64bit_hash.sv -----
// MurmurHash64A message hasher: controller plus datapath with one 32x32 multiplier.
// Each multiplication by the constant runs through load, three partial products and
// write-back. Before ready returns, an item needs one such multiplication if it is the
// first of a message, three for a full word or one for a short one, and one if it is
// last, plus an emit step on a last item; the emit step waits while the previous hash
// is unread. The hash is loaded into the output register in the emit state. One item at a time.
// Reset clears the seed, the running hash and all control state; no clearing pass.
module murmur2_64bit_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  mm64_in_if.sink     in_ch_i,
  mm64_out_if.source  out_ch_o
);
  import mm64_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  mm64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  mm64_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (in_ch_i.data_word),
    .count_i     (in_ch_i.byte_count),
    .len_i       (in_ch_i.total_length),
    .last_i      (in_ch_i.last),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .hash_o      (out_ch_o.hash)
  );

  // A new hash is only loaded when the output slot is free or being emptied.
  a_hash_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.hash_load |-> (!out_ch_o.valid || out_ch_o.ready))
    else $error("hash loaded over an unread result");

  // No item is taken while the multiplier is busy.
  a_accept_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ch_i.ready) |-> (dp_cmd.mul_phase == MP_NONE))
    else $error("item accepted during a multiplication");

  // The three partial products of a multiplication follow one another.
  a_mul_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.mul_phase == MP_LO) |=> (dp_cmd.mul_phase == MP_HI_LO) ##1
    (dp_cmd.mul_phase == MP_LO_HI))
    else $error("partial product sequence broken");

endmodule

// ----- tb/mm64_hash_checker.sv -----
`timescale 1ns / 100ps
// Checker for the MurmurHash64A message hasher: follows the seed register and both channels,
// predicts the hash of every finished message and compares it with the result item.
// Depends on mm64_pkg for the mixing constant and shift distance.
module mm64_hash_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic [31:0] total_length_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] hash_i,
  output int unsigned mismatches_o,
  output int unsigned results_pending_o
);
  import mm64_pkg::*;

  // Own copy of the seed register and the hashing state.
  logic [63:0] seed_q;
  logic [63:0] acc_hash_q;
  logic        in_msg_q;
  logic [63:0] hash_due_q[$];
  int unsigned mismatch_cnt = 0;

  // Multiply, shift-xor, multiply of one full message word.
  function automatic logic [63:0] scramble_word(input logic [63:0] k);
    logic [63:0] t;
    t = k * MixMul;
    t = t ^ (t >> MixShift);
    return t * MixMul;
  endfunction

  // Folds one item into the running hash; counts above eight act as a full word.
  function automatic logic [63:0] absorb_item(input logic [63:0] h, input logic [63:0] word,
                                              input logic [3:0] count);
    logic [63:0] mask;
    if (count >= 4'd8) return (h ^ scramble_word(word)) * MixMul;
    if (count == 4'd0) return h;
    mask = (64'd1 << (8 * count)) - 64'd1;
    return (h ^ (word & mask)) * MixMul;
  endfunction

  // Final avalanche applied on the last item of a message.
  function automatic logic [63:0] finish_hash(input logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> MixShift);
    t = t * MixMul;
    return t ^ (t >> MixShift);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (mismatch_cnt < 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  // Prediction on every accepted input item, comparison on every accepted result item.
  always @(posedge clk_i or negedge rst_ni) begin : follow
    logic [63:0] h;
    logic [63:0] want;
    if (!rst_ni) begin
      seed_q     <= '0;
      acc_hash_q <= '0;
      in_msg_q   <= 1'b0;
      hash_due_q.delete();
      results_pending_o <= 0;
      mismatches_o      <= 0;
    end else begin
      if (cfg_we_i) seed_q <= cfg_wdata_i;

      if (in_valid_i && in_ready_i) begin
        h = in_msg_q ? acc_hash_q : seed_q ^ ({32'd0, total_length_i} * MixMul);
        h = absorb_item(h, data_word_i, byte_count_i);
        if (last_i) begin
          h = finish_hash(h);
          hash_due_q.push_back(h);
          in_msg_q <= 1'b0;
        end else begin
          in_msg_q <= 1'b1;
        end
        acc_hash_q <= h;
      end

      if (out_valid_i && out_ready_i) begin
        if (hash_due_q.size() == 0) begin
          note_mismatch("hash item with no message finished", '0, hash_i);
        end else begin
          want = hash_due_q.pop_front();
          if (hash_i !== want) note_mismatch("hash mismatch", want, hash_i);
        end
      end

      results_pending_o <= hash_due_q.size();
      mismatches_o      <= mismatch_cnt;
    end
  end

endmodule

// ----- tb/tb_murmur2_64bit_hash.sv -----
`timescale 1ns / 100ps
// Top of the hasher testbench: clock, reset, seed writes, message stimulus and verdict.
// Depends on mm64_pkg, the two channel interfaces, the hasher and mm64_hash_checker.
module tb_murmur2_64bit_hash;
  import mm64_pkg::*;

  // Settle time before a seed write, so that the block has gone quiet.
  localparam int CfgSettle = 32;
  // Watchdog limit; it must exceed the longest quiet stretch of a correct run (sender gap,
  // block, receiver stall, settle time).
  localparam int WatchdogLimit = 1000;
  localparam int PhaseItems    = 90;
  localparam int NumPhases     = 7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;
  int unsigned mismatches;
  int unsigned results_pending;
  int unsigned items_sent = 0;
  int          send_burst_left = 0;
  int          recv_burst_left = 0;
  int          quiet_cycles = 0;

  mm64_in_if  in_ch ();
  mm64_out_if out_ch ();

  murmur2_64bit_hash uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch_i     (in_ch),
    .out_ch_o    (out_ch)
  );

  mm64_hash_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_ch.valid),
    .in_ready_i        (in_ch.ready),
    .data_word_i       (in_ch.data_word),
    .byte_count_i      (in_ch.byte_count),
    .total_length_i    (in_ch.total_length),
    .last_i            (in_ch.last),
    .out_valid_i       (out_ch.valid),
    .out_ready_i       (out_ch.ready),
    .hash_i            (out_ch.hash),
    .mismatches_o      (mismatches),
    .results_pending_o (results_pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: ends the run once nothing has moved on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("** murmur2_64bit_hash: FAILED **");
      $finish;
    end
  end

  // Result receiver: random stalls per item, with occasional runs of no stall at all.
  initial begin : receiver
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      if (recv_burst_left > 0) begin
        gap = 0;
        recv_burst_left--;
      end else begin
        if ($urandom_range(0, 15) == 0) recv_burst_left = 20;
        gap = $urandom_range(0, 18);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Offers one item after a random gap and waits until it is taken; valid stays high
  // when the next item follows without a gap.
  task automatic send_item(input logic [63:0] data, input logic [3:0] count,
                           input logic [31:0] len, input logic fin);
    int gap;
    gap = (send_burst_left > 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_word    <= data;
    in_ch.byte_count   <= count;
    in_ch.total_length <= len;
    in_ch.last         <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Holds the sender back until every finished message has produced its hash.
  task automatic drain_hashes();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  // Writes the seed once the block has gone quiet.
  task automatic write_seed(input logic [63:0] value);
    drain_hashes();
    repeat (CfgSettle) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // One random message: mostly well-formed full words and a tail with a matching length,
  // sometimes odd byte counts anywhere and a length unrelated to the data.
  task automatic send_message();
    int          n_full;
    int          tail;
    bit          noisy;
    logic [31:0] len;
    if (send_burst_left > 0) send_burst_left--;
    else if ($urandom_range(0, 9) == 0) send_burst_left = 8;
    n_full = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    tail   = $urandom_range(0, 8);
    noisy  = ($urandom_range(0, 5) == 0);
    len    = ($urandom_range(0, 7) == 0) ? $urandom() : 32'(8 * n_full + tail);
    for (int i = 0; i < n_full; i++) begin
      send_item(rand_word(), noisy ? 4'($urandom_range(0, 15)) : 4'd8,
                (i == 0) ? len : $urandom(), 1'b0);
    end
    send_item(rand_word(), noisy ? 4'($urandom_range(0, 15)) : 4'(tail),
              (n_full == 0) ? len : $urandom(), 1'b1);
  endtask

  // Main sequence: reset, directed messages at the reset seed, then random phases.
  initial begin : stimulus
    int unsigned phase_start;
    logic [63:0] seed_val;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.data_word    <= '0;
    in_ch.byte_count   <= '0;
    in_ch.total_length <= '0;
    in_ch.last         <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty messages at both length extremes.
    send_item(rand_word(), 4'd0, 32'd0, 1'b1);
    send_item('1, 4'd0, 32'hFFFF_FFFF, 1'b1);
    // Single full words with all-zero and all-one data, then a count above eight.
    send_item('0, 4'd8, 32'd8, 1'b1);
    send_item('1, 4'd8, 32'd8, 1'b1);
    send_item(rand_word(), 4'd15, 32'd8, 1'b1);
    // Every short final word; the unused upper bytes are all ones and must be ignored.
    for (int c = 1; c < 8; c++) send_item('1, 4'(c), 32'(c), 1'b1);
    // Short and empty words before the end, and a length that does not fit the data.
    send_item(rand_word(), 4'd8, 32'd37, 1'b0);
    send_item(rand_word(), 4'd3, '1, 1'b0);
    send_item(rand_word(), 4'd0, '0, 1'b0);
    send_item(rand_word(), 4'd9, $urandom(), 1'b0);
    send_item(rand_word(), 4'd5, $urandom(), 1'b1);

    // Random phases, each under its own seed; the extremes come first.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: seed_val = '1;
        1: seed_val = '0;
        2: seed_val = 64'h8000_0000_0000_0000;
        3: seed_val = 64'h0000_0000_0000_0001;
        default: seed_val = rand_word();
      endcase
      write_seed(seed_val);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        send_message();
        if ($urandom_range(0, 11) == 0) drain_hashes();
      end
    end

    // Wind down and give the verdict.
    drain_hashes();
    repeat (CfgSettle) @(posedge clk_i);
    if (mismatches == 0 && results_pending == 0) begin
      $display("** murmur2_64bit_hash: PASSED **");
    end else begin
      $display("** murmur2_64bit_hash: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mm64_pkg.sv
sv/mm64_in_if.sv
sv/mm64_out_if.sv
sv/mm64_dp.sv
sv/mm64_ctrl.sv
sv/murmur2_64bit_hash.sv
tb/mm64_hash_checker.sv
tb/tb_murmur2_64bit_hash.sv
